>>> src/lc3s_pkg.sv
`default_nettype none
package lc3s_pkg;

   // command codes of a request beat
   localparam logic [1:0] CMD_MEM_WRITE = 2'd0;
   localparam logic [1:0] CMD_REG_WRITE = 2'd1;
   localparam logic [1:0] CMD_EXECUTE   = 2'd2;

   // special register indexes for a register write
   localparam logic [3:0] REG_IDX_PC   = 4'd8;
   localparam logic [3:0] REG_IDX_COND = 4'd9;

   // opcodes
   localparam logic [3:0] OP_BR   = 4'd0;
   localparam logic [3:0] OP_ADD  = 4'd1;
   localparam logic [3:0] OP_LD   = 4'd2;
   localparam logic [3:0] OP_ST   = 4'd3;
   localparam logic [3:0] OP_JSR  = 4'd4;
   localparam logic [3:0] OP_AND  = 4'd5;
   localparam logic [3:0] OP_LDR  = 4'd6;
   localparam logic [3:0] OP_STR  = 4'd7;
   localparam logic [3:0] OP_NOT  = 4'd9;
   localparam logic [3:0] OP_LDI  = 4'd10;
   localparam logic [3:0] OP_STI  = 4'd11;
   localparam logic [3:0] OP_JMP  = 4'd12;
   localparam logic [3:0] OP_LEA  = 4'd14;
   localparam logic [3:0] OP_TRAP = 4'd15;

   localparam logic [7:0] TRAP_HALT = 8'h25;

   // condition codes
   localparam logic [2:0] FLAG_P = 3'b001;
   localparam logic [2:0] FLAG_Z = 3'b010;
   localparam logic [2:0] FLAG_N = 3'b100;

   localparam logic [2:0] LINK_REG = 3'd7;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] address;
      logic [3:0]  reg_index;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic [15:0] fetched_word;
      logic [15:0] next_pc;
      logic [15:0] step_value;
      logic [2:0]  cond_flags;
      logic        halted;
   } rsp_type;

   // word memory access, one port
   typedef struct packed {
      logic        wr_en;
      logic        rd_en;
      logic [15:0] addr;
      logic [15:0] wdata;
   } mem_cmd_type;

   // register file access, one write and two reads
   typedef struct packed {
      logic        wr_en;
      logic [2:0]  wr_idx;
      logic [15:0] wdata;
      logic        rd_en;
      logic [2:0]  rd_a_idx;
      logic [2:0]  rd_b_idx;
   } reg_cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECODE = 5'b00010,
      ST_EXEC   = 5'b00100,
      ST_MEM1   = 5'b01000,
      ST_MEM2   = 5'b10000
   } state_type;

   function automatic logic [2:0] flags_of(input logic [15:0] v);
      logic [2:0] f;
      if (v == 16'd0) begin
         f = FLAG_Z;
      end else if (v[15]) begin
         f = FLAG_N;
      end else begin
         f = FLAG_P;
      end
      return f;
   endfunction

endpackage
`default_nettype wire

>>> src/lc3s_word_mem.sv
`default_nettype none
module lc3s_word_mem #(
   parameter int ADDR_BITS = 16
) (
   input  wire logic                clock,
   input  wire lc3s_pkg::mem_cmd_type mem_cmd,
   output logic [15:0]              rd_data
);
   import lc3s_pkg::*;

   logic [15:0] mem_array [2**ADDR_BITS];
   logic [15:0] rd_data_ff;
   logic [ADDR_BITS-1:0] word_addr;

   assign word_addr = mem_cmd.addr[ADDR_BITS-1:0];

   // single port, registered read
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem_array[word_addr] <= mem_cmd.wdata;
      end
      if (mem_cmd.rd_en) begin
         rd_data_ff <= mem_array[word_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> src/lc3s_reg_file.sv
`default_nettype none
module lc3s_reg_file (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lc3s_pkg::reg_cmd_type reg_cmd,
   output logic [15:0]              rd_a,
   output logic [15:0]              rd_b
);
   import lc3s_pkg::*;

   logic [15:0] reg_array [8];
   logic [7:0]  valid_ff;
   logic [15:0] rd_a_ff;
   logic [15:0] rd_b_ff;

   // valid bits: an entry not written since reset reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (reg_cmd.wr_en) begin
         valid_ff[reg_cmd.wr_idx] <= 1'b1;
      end
   end

   // write port and two registered read ports
   always_ff @(posedge clock) begin
      if (reg_cmd.wr_en) begin
         reg_array[reg_cmd.wr_idx] <= reg_cmd.wdata;
      end
      if (reg_cmd.rd_en) begin
         rd_a_ff <= valid_ff[reg_cmd.rd_a_idx] ? reg_array[reg_cmd.rd_a_idx] : 16'd0;
         rd_b_ff <= valid_ff[reg_cmd.rd_b_idx] ? reg_array[reg_cmd.rd_b_idx] : 16'd0;
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule
`default_nettype wire

>>> src/lc3_instruction_step_core.sv
`default_nettype none
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  lc3s_pkg::req_type (command, address, ...)
// rsp       out        rsp_valid / rsp_stall  lc3s_pkg::rsp_type (fetched_word, next_pc, ...)
//
// a request beat lands in an input buffer and starts once the core is idle and the response buffer is free; one
// command runs at a time through the single port of the word memory
// memory or register write: done in IDLE; ALU, branch, jump, trap, ST, STR: DECODE, EXEC
// LD, LDR, STI: DECODE, EXEC, MEM1; LDI: adds MEM2 (fetch plus up to two dependent memory reads)
// synchronous reset clears registers, PC, flags and both buffers; memory is not cleared
// a stalled response holds; the input buffer still takes one beat meanwhile
module lc3_instruction_step_core #(
   parameter int ADDR_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lc3s_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output lc3s_pkg::rsp_type      rsp_data
);
   import lc3s_pkg::*;

   state_type   state_ff, state_in;
   logic        in_valid_ff, in_valid_in;
   req_type     in_data_ff;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_data_ff, out_data_in;
   logic [15:0] inst_ff, inst_in;
   logic [15:0] pc_ff, pc_in;
   logic [2:0]  cond_ff, cond_in;
   logic [15:0] store_ff, store_in;

   mem_cmd_type mem_cmd;
   reg_cmd_type reg_cmd;
   logic [15:0] mem_rd;
   logic [15:0] reg_a;
   logic [15:0] reg_b;

   logic        req_take;
   logic        out_free;
   logic        start;
   logic        finish;
   logic        halt;

   logic [3:0]  opcode;
   logic [3:0]  dec_op;
   logic [2:0]  dr;
   logic [15:0] off9;
   logic [15:0] off6;
   logic [15:0] off11;
   logic [15:0] operand;
   logic [15:0] addr9;
   logic [15:0] addr6;
   logic [15:0] alu_add;
   logic [15:0] alu_and;

   lc3s_word_mem #(.ADDR_BITS(ADDR_BITS)) u_word_mem (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .rd_data (mem_rd)
   );

   lc3s_reg_file u_reg_file (
      .clock   (clock),
      .reset   (reset),
      .reg_cmd (reg_cmd),
      .rd_a    (reg_a),
      .rd_b    (reg_b)
   );

   // handshakes
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign start     = (state_ff == ST_IDLE) && in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !start;
   assign req_take  = req_valid && !req_stall;

   // instruction fields
   assign opcode  = inst_ff[15:12];
   assign dec_op  = mem_rd[15:12];
   assign dr      = inst_ff[11:9];
   assign off9    = {{7{inst_ff[8]}}, inst_ff[8:0]};
   assign off6    = {{10{inst_ff[5]}}, inst_ff[5:0]};
   assign off11   = {{5{inst_ff[10]}}, inst_ff[10:0]};
   assign operand = inst_ff[5] ? {{11{inst_ff[4]}}, inst_ff[4:0]} : reg_b;
   assign addr9   = pc_ff + off9;
   assign addr6   = reg_a + off6;
   assign alu_add = reg_a + operand;
   assign alu_and = reg_a & operand;

   // sequencer
   always_comb begin
      state_in = state_ff;
      inst_in  = inst_ff;
      pc_in    = pc_ff;
      cond_in  = cond_ff;
      store_in = store_ff;
      mem_cmd  = '0;
      reg_cmd  = '0;
      finish   = 1'b0;
      halt     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (in_data_ff.command)
                  CMD_MEM_WRITE: begin
                     mem_cmd.wr_en = 1'b1;
                     mem_cmd.addr  = in_data_ff.address;
                     mem_cmd.wdata = in_data_ff.value;
                     finish        = 1'b1;
                  end
                  CMD_REG_WRITE: begin
                     if (!in_data_ff.reg_index[3]) begin
                        reg_cmd.wr_en  = 1'b1;
                        reg_cmd.wr_idx = in_data_ff.reg_index[2:0];
                        reg_cmd.wdata  = in_data_ff.value;
                     end else if (in_data_ff.reg_index == REG_IDX_PC) begin
                        pc_in = in_data_ff.value;
                     end else if (in_data_ff.reg_index == REG_IDX_COND) begin
                        cond_in = in_data_ff.value[2:0];
                     end
                     finish = 1'b1;
                  end
                  CMD_EXECUTE: begin
                     mem_cmd.rd_en = 1'b1;
                     mem_cmd.addr  = pc_ff;
                     state_in      = ST_DECODE;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         ST_DECODE: begin
            // fetched word arrives; read the two source registers
            inst_in          = mem_rd;
            pc_in            = pc_ff + 16'd1;
            reg_cmd.rd_en    = 1'b1;
            reg_cmd.rd_a_idx = mem_rd[8:6];
            reg_cmd.rd_b_idx = (dec_op == OP_ST || dec_op == OP_STI || dec_op == OP_STR)
                               ? mem_rd[11:9] : mem_rd[2:0];
            state_in         = ST_EXEC;
         end
         ST_EXEC: begin
            store_in = reg_b;
            finish   = 1'b1;
            state_in = ST_IDLE;
            unique case (opcode)
               OP_ADD, OP_AND: begin
                  reg_cmd.wr_en  = 1'b1;
                  reg_cmd.wr_idx = dr;
                  reg_cmd.wdata  = (opcode == OP_ADD) ? alu_add : alu_and;
                  cond_in        = flags_of(reg_cmd.wdata);
               end
               OP_NOT: begin
                  reg_cmd.wr_en  = 1'b1;
                  reg_cmd.wr_idx = dr;
                  reg_cmd.wdata  = ~reg_a;
                  cond_in        = flags_of(~reg_a);
               end
               OP_LEA: begin
                  reg_cmd.wr_en  = 1'b1;
                  reg_cmd.wr_idx = dr;
                  reg_cmd.wdata  = addr9;
                  cond_in        = flags_of(addr9);
               end
               OP_BR: begin
                  if ((dr & cond_ff) != 3'd0) begin
                     pc_in = addr9;
                  end
               end
               OP_JMP: begin
                  pc_in = reg_a;
               end
               OP_JSR: begin
                  // base register was read before the link write
                  reg_cmd.wr_en  = 1'b1;
                  reg_cmd.wr_idx = LINK_REG;
                  reg_cmd.wdata  = pc_ff;
                  pc_in          = inst_ff[11] ? (pc_ff + off11) : reg_a;
               end
               OP_LD, OP_LDI, OP_STI: begin
                  mem_cmd.rd_en = 1'b1;
                  mem_cmd.addr  = addr9;
                  finish        = 1'b0;
                  state_in      = ST_MEM1;
               end
               OP_LDR: begin
                  mem_cmd.rd_en = 1'b1;
                  mem_cmd.addr  = addr6;
                  finish        = 1'b0;
                  state_in      = ST_MEM1;
               end
               OP_ST: begin
                  mem_cmd.wr_en = 1'b1;
                  mem_cmd.addr  = addr9;
                  mem_cmd.wdata = reg_b;
               end
               OP_STR: begin
                  mem_cmd.wr_en = 1'b1;
                  mem_cmd.addr  = addr6;
                  mem_cmd.wdata = reg_b;
               end
               OP_TRAP: begin
                  if (inst_ff[7:0] == TRAP_HALT) begin
                     pc_in = 16'd0;
                     halt  = 1'b1;
                  end
               end
               default: begin
                  // RTI, reserved: only the PC step
               end
            endcase
         end
         ST_MEM1: begin
            if (opcode == OP_LDI) begin
               mem_cmd.rd_en = 1'b1;
               mem_cmd.addr  = mem_rd;
               state_in      = ST_MEM2;
            end else if (opcode == OP_STI) begin
               mem_cmd.wr_en = 1'b1;
               mem_cmd.addr  = mem_rd;
               mem_cmd.wdata = store_ff;
               finish        = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               reg_cmd.wr_en  = 1'b1;
               reg_cmd.wr_idx = dr;
               reg_cmd.wdata  = mem_rd;
               cond_in        = flags_of(mem_rd);
               finish         = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_MEM2: begin
            reg_cmd.wr_en  = 1'b1;
            reg_cmd.wr_idx = dr;
            reg_cmd.wdata  = mem_rd;
            cond_in        = flags_of(mem_rd);
            finish         = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response beat contents
   always_comb begin
      out_data_in.fetched_word = (state_ff == ST_IDLE) ? 16'd0 : inst_ff;
      out_data_in.next_pc      = pc_in;
      out_data_in.step_value   = (out_data_in.fetched_word != 16'd0) ? pc_in : 16'd0;
      out_data_in.cond_flags   = cond_in;
      out_data_in.halted       = halt;
   end

   // buffer occupancy
   always_comb begin
      priority if (req_take) begin
         in_valid_in = 1'b1;
      end else if (start) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      priority if (finish) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff        <= 16'd0;
         cond_ff      <= 3'd0;
      end else begin
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pc_ff        <= pc_in;
         cond_ff      <= cond_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (finish) begin
         out_data_ff <= out_data_in;
      end
      inst_ff  <= inst_in;
      store_ff <= store_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
`default_nettype wire

>>> src/lc3s_port_checker.sv
`default_nettype none
module lc3s_port_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire lc3s_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire lc3s_pkg::rsp_type rsp_data
);
   import lc3s_pkg::*;

   // a stalled request beat stays with its contents
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request beat changed");

   // a stalled response beat stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // and keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled response beat changed");

   // halt leaves the PC at zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.halted |-> rsp_data.next_pc == 16'd0 &&
         rsp_data.fetched_word[15:12] == OP_TRAP)
      else $error("halt without trap or with nonzero PC");

   // step value follows the fetched word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.fetched_word == 16'd0 && rsp_data.step_value == 16'd0) ||
         (rsp_data.fetched_word != 16'd0 && rsp_data.step_value == rsp_data.next_pc))
      else $error("step value inconsistent with fetched word");

endmodule

bind lc3_instruction_step_core lc3s_port_checker u_port_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

>>> bench/lc3_instruction_step_core_tb.sv
`timescale 1ns / 1ps

module lc3_instruction_step_core_tb;
   import lc3s_pkg::*;

   // codes that the package leaves unnamed
   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam logic [3:0] OP_RTI      = 4'd8;
   localparam logic [3:0] OP_RESERVED = 4'd13;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      req_type req;
      rsp_type rsp;
   } step_job_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // architectural state of the predicted core
   logic [15:0] model_gpr [8];
   logic [15:0] model_pc;
   logic [2:0]  model_cond;
   logic [15:0] model_mem [65536];
   bit          model_mem_set [65536];

   step_job_type pending_steps[$];
   rsp_type      outstanding_rsps[$];
   step_job_type offered_job;
   rsp_type      checked_rsp;

   int unsigned req_gap_pct;
   int unsigned rsp_hold_pct;
   int unsigned holds_asked = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned mismatches = 0;

   lc3_instruction_step_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // data memory store, tracked so that no unwritten word is ever read
   function automatic void mem_store(logic [15:0] addr, logic [15:0] data);
      model_mem[addr] = data;
      model_mem_set[addr] = 1'b1;
   endfunction

   // one command applied to the predicted core, returning its response
   function automatic rsp_type lc3_predict(req_type r);
      rsp_type     o;
      logic [15:0] inst;
      logic [15:0] ea;
      logic [15:0] t;
      logic [15:0] v;
      logic [15:0] off9;
      logic [15:0] off6;
      logic [3:0]  op;
      logic [2:0]  dr;
      logic [2:0]  sr1;
      logic        set_cc;
      logic        halt;
      o = '0;
      inst = '0;
      v = '0;
      set_cc = 1'b0;
      halt = 1'b0;
      case (r.command)
         CMD_MEM_WRITE: begin
            mem_store(r.address, r.value);
         end
         CMD_REG_WRITE: begin
            if (r.reg_index < 4'd8) begin
               model_gpr[r.reg_index[2:0]] = r.value;
            end else if (r.reg_index == REG_IDX_PC) begin
               model_pc = r.value;
            end else if (r.reg_index == REG_IDX_COND) begin
               model_cond = r.value[2:0];
            end
         end
         CMD_EXECUTE: begin
            inst = model_mem[model_pc];
            model_pc = model_pc + 16'd1;
            op = inst[15:12];
            dr = inst[11:9];
            sr1 = inst[8:6];
            off9 = {{7{inst[8]}}, inst[8:0]};
            off6 = {{10{inst[5]}}, inst[5:0]};
            case (op)
               OP_ADD, OP_AND: begin
                  t = inst[5] ? {{11{inst[4]}}, inst[4:0]} : model_gpr[inst[2:0]];
                  v = (op == OP_ADD) ? model_gpr[sr1] + t : model_gpr[sr1] & t;
                  model_gpr[dr] = v;
                  set_cc = 1'b1;
               end
               OP_BR: begin
                  if ((dr & model_cond) != 3'd0) model_pc = model_pc + off9;
               end
               OP_JMP: begin
                  model_pc = model_gpr[sr1];
               end
               OP_JSR: begin
                  // base register is read before the link register is written
                  t = inst[11] ? model_pc + {{5{inst[10]}}, inst[10:0]} : model_gpr[sr1];
                  model_gpr[LINK_REG] = model_pc;
                  model_pc = t;
               end
               OP_LD, OP_LDI, OP_LDR: begin
                  ea = (op == OP_LDR) ? model_gpr[sr1] + off6 : model_pc + off9;
                  v = model_mem[ea];
                  if (op == OP_LDI) v = model_mem[v];
                  model_gpr[dr] = v;
                  set_cc = 1'b1;
               end
               OP_LEA: begin
                  v = model_pc + off9;
                  model_gpr[dr] = v;
                  set_cc = 1'b1;
               end
               OP_NOT: begin
                  v = ~model_gpr[sr1];
                  model_gpr[dr] = v;
                  set_cc = 1'b1;
               end
               OP_ST: begin
                  mem_store(model_pc + off9, model_gpr[dr]);
               end
               OP_STI: begin
                  ea = model_pc + off9;
                  mem_store(model_mem[ea], model_gpr[dr]);
               end
               OP_STR: begin
                  mem_store(model_gpr[sr1] + off6, model_gpr[dr]);
               end
               OP_TRAP: begin
                  if (inst[7:0] == TRAP_HALT) begin
                     model_pc = '0;
                     halt = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            if (set_cc) begin
               model_cond = (v == 16'd0) ? FLAG_Z : (v[15] ? FLAG_N : FLAG_P);
            end
            o.fetched_word = inst;
            o.step_value = (inst != 16'd0) ? model_pc : 16'd0;
            o.halted = halt;
         end
         default: begin
         end
      endcase
      o.next_pc = model_pc;
      o.cond_flags = model_cond;
      return o;
   endfunction

   function automatic req_type make_req(logic [1:0] cmd, logic [15:0] addr,
                                        logic [3:0] idx, logic [15:0] val);
      req_type r;
      r.command = cmd;
      r.address = addr;
      r.reg_index = idx;
      r.value = val;
      return r;
   endfunction

   function automatic logic [15:0] rand_word();
      return 16'($urandom);
   endfunction

   // random instruction word, halt traps and zero words made more likely
   function automatic logic [15:0] rand_inst();
      logic [15:0] w;
      w = rand_word();
      if (w[15:12] == OP_TRAP && w[0]) w[11:0] = {4'd0, TRAP_HALT};
      if ($urandom_range(49) == 0) w = '0;
      return w;
   endfunction

   task automatic post_beat(input req_type r);
      step_job_type job;
      job.req = r;
      job.rsp = lc3_predict(r);
      pending_steps.push_back(job);
   endtask

   task automatic ensure_word(input logic [15:0] addr);
      if (!model_mem_set[addr]) begin
         post_beat(make_req(CMD_MEM_WRITE, addr, 4'($urandom), rand_word()));
      end
   endtask

   // make sure every word the next step reads has been written, then execute
   task automatic run_one_step();
      logic [15:0] inst;
      logic [15:0] ea;
      ensure_word(model_pc);
      inst = model_mem[model_pc];
      case (inst[15:12])
         OP_LD, OP_LDI, OP_STI: begin
            ea = model_pc + 16'd1 + {{7{inst[8]}}, inst[8:0]};
            ensure_word(ea);
            if (inst[15:12] == OP_LDI) ensure_word(model_mem[ea]);
         end
         OP_LDR: begin
            ensure_word(model_gpr[inst[8:6]] + {{10{inst[5]}}, inst[5:0]});
         end
         default: begin
         end
      endcase
      post_beat(make_req(CMD_EXECUTE, rand_word(), 4'($urandom), rand_word()));
   endtask

   task automatic exec_word(input logic [15:0] inst);
      post_beat(make_req(CMD_MEM_WRITE, model_pc, 4'($urandom), inst));
      run_one_step();
   endtask

   // mostly short program runs, with register and memory pokes mixed in
   task automatic random_items(input int count);
      int unsigned pick;
      logic [15:0] addr;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            addr = $urandom_range(1) ? model_pc + 16'($urandom_range(31)) : rand_word();
            post_beat(make_req(CMD_MEM_WRITE, addr, 4'($urandom),
                               $urandom_range(1) ? rand_inst() : rand_word()));
         end else if (pick < 20) begin
            post_beat(make_req(CMD_REG_WRITE, rand_word(), 4'($urandom), rand_word()));
         end else if (pick < 22) begin
            post_beat(make_req(CMD_UNUSED, rand_word(), 4'($urandom), rand_word()));
         end else begin
            if (!model_mem_set[model_pc] || $urandom_range(99) < 45) begin
               post_beat(make_req(CMD_MEM_WRITE, model_pc, 4'($urandom), rand_inst()));
            end
            run_one_step();
         end
      end
   endtask

   // wait until every queued beat has gone in and every response come back
   task automatic drain();
      @(negedge clock);
      while (pending_steps.size() != 0 || req_valid || outstanding_rsps.size() != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) outstanding_rsps.push_back(offered_job.rsp);
         if (!req_valid || !req_stall) begin
            if (pending_steps.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
               offered_job = pending_steps.pop_front();
               req_data <= offered_job.req;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outstanding_rsps.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatches++;
            end else begin
               checked_rsp = outstanding_rsps.pop_front();
               compare_field("fetched_word", checked_rsp.fetched_word, rsp_data.fetched_word);
               compare_field("next_pc", checked_rsp.next_pc, rsp_data.next_pc);
               compare_field("step_value", checked_rsp.step_value, rsp_data.step_value);
               compare_field("cond_flags", 16'(checked_rsp.cond_flags),
                             16'(rsp_data.cond_flags));
               compare_field("halted", 16'(checked_rsp.halted), 16'(rsp_data.halted));
            end
         end
         // long hold-off on request, otherwise random stalls
         if (holds_served != holds_asked) begin
            hold_left = HOLD_CYCLES;
            holds_served = holds_asked;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      foreach (model_gpr[i]) model_gpr[i] = '0;
      model_pc = '0;
      model_cond = '0;
      req_gap_pct = 11;
      rsp_hold_pct = 87;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // extreme register values, condition write keeps low bits only
      post_beat(make_req(CMD_REG_WRITE, 16'hFFFF, 4'd1, 16'h7FFF));
      post_beat(make_req(CMD_REG_WRITE, 16'h0000, 4'd2, 16'h8000));
      post_beat(make_req(CMD_REG_WRITE, 16'hFFFF, 4'd3, 16'hFFFF));
      post_beat(make_req(CMD_REG_WRITE, 16'h0000, REG_IDX_COND, 16'hFFFD));
      // out of range register index and unused command change nothing
      post_beat(make_req(CMD_REG_WRITE, 16'h5555, 4'd15, 16'hBEEF));
      post_beat(make_req(CMD_UNUSED, 16'hAAAA, 4'd0, 16'hFFFF));
      // pc wraps from the top of memory
      post_beat(make_req(CMD_REG_WRITE, 16'h0000, REG_IDX_PC, 16'hFFFF));
      exec_word({OP_ADD, 3'd4, 3'd1, 1'b1, 5'h10});
      exec_word({OP_ADD, 3'd5, 3'd1, 3'b000, 3'd2});
      exec_word({OP_AND, 3'd6, 3'd3, 1'b1, 5'd0});
      exec_word(16'h0000);
      exec_word({OP_NOT, 3'd0, 3'd3, 6'h3F});
      exec_word({OP_BR, 3'b111, 9'h100});
      exec_word({OP_JSR, 1'b1, 11'h3FF});
      // jsrr through the link register itself
      exec_word({OP_JSR, 3'b000, LINK_REG, 6'd0});
      exec_word({OP_LDI, 3'd1, 9'h0FF});
      exec_word({OP_TRAP, 4'd0, TRAP_HALT});
      exec_word({OP_RTI, 12'd0});
      exec_word({OP_RESERVED, 12'hFFF});

      random_items(350);
      drain();

      req_gap_pct = 87;
      rsp_hold_pct = 11;
      random_items(350);
      drain();

      // no idling, with one long receiver hold while the queue is full
      req_gap_pct = 0;
      rsp_hold_pct = 0;
      random_items(200);
      holds_asked++;
      random_items(200);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding_rsps.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/lc3s_pkg.sv
src/lc3s_word_mem.sv
src/lc3s_reg_file.sv
src/lc3_instruction_step_core.sv
src/lc3s_port_checker.sv
bench/lc3_instruction_step_core_tb.sv
